@@ hdl/set_assoc_cache_lookup_replace_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative cache lookup block
// Shared property templates, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LOOKUP_REPLACE_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LOOKUP_REPLACE_TOP_DEFINES_SVH

// same-cycle implication
`define SACL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacl: same-cycle check failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacl: next-cycle check failed");

`endif

@@ hdl/sacl_pkg.sv @@
// ---------------------------------------------------------------------------
// sacl_pkg
// Types and constants of the set-associative cache lookup block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sacl_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 32;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = $clog2(MAX_WAYS);
  localparam int AGE_W     = 3;
  localparam int FILL_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_STEPS = 16;

  localparam logic [AGE_W-1:0]     AGE_TOP    = 3'd7;
  localparam logic [FILL_W-1:0]    FILL_TOP   = 4'd15;
  localparam logic [CFG_DAT_W-1:0] SEED_RESET = 16'd44257;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_BITS = 3'd0,
    REG_INDEX_BITS  = 3'd1,
    REG_WAYS_IN_USE = 3'd2,
    REG_POLICY_MODE = 3'd3,
    REG_RANDOM_SEED = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    POL_LRU    = 2'd0,
    POL_MRU    = 2'd1,
    POL_RANDOM = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_WRITE
  } state_t;

  // one set: fill count, ages and stored addresses of all ways
  typedef struct packed {
    logic [FILL_W-1:0]                   fill;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0]  addr;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

@@ hdl/sacl_if.sv @@
// ---------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels for lookup requests and lookup results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface sacl_req_if import sacl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           outcome;
  logic [ADDR_BITS-1:0] evicted_address;
  modport source (output valid, output outcome, output evicted_address, input ready);
  modport sink   (input valid, input outcome, input evicted_address, output ready);
endinterface

@@ hdl/set_assoc_cache_lookup_replace_top.sv @@
// ---------------------------------------------------------------------------
// set_assoc_cache_lookup_replace_top
// Set-associative cache lookup with LRU / MRU / random replacement.
// ---------------------------------------------------------------------------
//  channel | dir | fields                          | transfer
//  req     | in  | address[31:0]                   | req.valid & req.ready
//  rsp     | out | outcome[1:0], evicted[31:0]     | rsp.valid & rsp.ready
//  cfg     | in  | cfg_index[2:0], cfg_data[15:0]  | cfg_we
//
//  Steps: accept + set read in idle, then the scan of the active ways (ways_in_use
//  clamped to 1..8; one way per cycle through the shared tag/age compare), for
//  random eviction a bit-serial remainder of the 16-bit LFSR by the way count
//  (same subtract unit), then write-back.
//  Reset: rst clears the per-set valid flags at once; no clearing pass.
//  req is taken only in idle; a result waiting in rsp holds only write-back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_lookup_replace_top_defines.svh"
module set_assoc_cache_lookup_replace_top import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  sacl_req_if.sink             req,
  sacl_rsp_if.source           rsp
);

  // configuration
  logic [4:0]  offset_bits;
  logic [3:0]  index_bits;
  logic [3:0]  ways_in_use;
  logic [1:0]  policy_mode;
  logic [15:0] lfsr;

  state_t state, state_next;

  logic [ADDR_BITS-1:0] addr_q;
  logic [SET_W-1:0]     set_q;
  logic [MAX_SETS-1:0]  row_valid;
  logic [WAY_W-1:0]     way;
  logic                 hit_found, free_found;
  logic [WAY_W-1:0]     hit_way, free_way, victim;
  logic [AGE_W-1:0]     best_age;
  logic [WAY_W-1:0]     rem;
  logic [3:0]           div_cnt;

  logic [ROW_W-1:0] ram_rdata;
  row_t             row, row_new;
  logic             ram_we;
  logic [SET_W-1:0] rd_set;

  logic [3:0]  nw;
  logic [3:0]  fill;
  logic [5:0]  tag_sh;
  logic [ADDR_BITS-1:0] diff_sh;
  logic        way_valid, way_match, scan_last, accept;
  logic [AGE_W-1:0] way_age;
  logic [15:0] lfsr_adv;
  logic [ADDR_BITS-1:0] set_sh;
  logic [7:0]  set_mask;
  logic [WAY_W:0] div_r;

  logic [1:0]       kind;
  logic [WAY_W-1:0] tway;
  logic [AGE_W:0]   limit;

  // ---- config port; a seed write reloads the LFSR (zero loads as one)
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 5'd4;
      index_bits  <= 4'd4;
      ways_in_use <= 4'd2;
      policy_mode <= POL_LRU;
      lfsr        <= SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[4:0];
        REG_INDEX_BITS:  index_bits  <= cfg_data[3:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        REG_POLICY_MODE: policy_mode <= cfg_data[1:0];
        REG_RANDOM_SEED: lfsr <= (cfg_data == '0) ? 16'd1 : cfg_data;
        default: ;
      endcase
    end else if (state == ST_SCAN && scan_last && !hit_found && !way_match &&
                 !free_found && way_valid && policy_mode == POL_RANDOM) begin
      lfsr <= lfsr_adv;
    end
  end

  assign lfsr_adv = {lfsr[14:0], lfsr[15] ^ lfsr[13] ^ lfsr[12] ^ lfsr[10]};

  // active way count, clamped to 1..MAX_WAYS
  always_comb begin
    if (ways_in_use == 4'd0) nw = 4'd1;
    else if (ways_in_use > 4'(MAX_WAYS)) nw = 4'(MAX_WAYS);
    else nw = ways_in_use;
  end

  // set index from the incoming address
  assign set_sh   = req.address >> offset_bits;
  assign set_mask = (index_bits >= 4'd8) ? 8'hFF : 8'((9'd1 << index_bits) - 9'd1);
  assign rd_set   = set_sh[SET_W-1:0] & set_mask;
  assign accept   = req.valid && req.ready;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_q),
    .wdata (row_new),
    .re    (accept),
    .raddr (rd_set),
    .rdata (ram_rdata)
  );

  assign row  = row_t'(ram_rdata);
  // an untouched set has no valid lines
  assign fill = row_valid[set_q] ? row.fill : 4'd0;

  // ---- shared per-way unit: tag compare and age compare for way 'way'
  assign tag_sh    = {1'b0, offset_bits} + {2'b00, index_bits};
  assign diff_sh   = (row.addr[way] ^ addr_q) >> tag_sh[4:0];
  assign way_valid = {1'b0, way} < fill;
  assign way_match = way_valid && (tag_sh[5] || diff_sh == '0);
  assign way_age   = row.age[way];
  assign scan_last = {1'b0, way} == nw - 4'd1;

  // ---- remainder step: shift one LFSR bit in, subtract way count if it fits
  always_comb begin
    div_r = {rem, lfsr[div_cnt]};
    if (div_r >= nw) div_r = div_r - nw;
  end

  // ---- write-back row
  always_comb begin
    if (hit_found) begin
      kind  = OUT_HIT;
      tway  = hit_way;
      limit = {1'b0, row.age[hit_way]};
    end else if (free_found) begin
      kind  = OUT_FILL;
      tway  = free_way;
      limit = {1'b1, {AGE_W{1'b0}}};
    end else begin
      kind  = OUT_EVICT;
      tway  = victim;
      limit = {1'b0, row.age[victim]};
    end
    row_new      = row;
    row_new.fill = fill;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (4'(i) < nw && 4'(i) < fill && {1'b0, row.age[i]} < limit &&
          row.age[i] < AGE_TOP) begin
        row_new.age[i] = row.age[i] + 3'd1;
      end
    end
    row_new.age[tway] = '0;
    if (kind != OUT_HIT) begin
      row_new.addr[tway] = addr_q;
    end
    if (kind == OUT_FILL && fill < FILL_TOP) begin
      row_new.fill = fill + 4'd1;
    end
  end

  assign ram_we = (state == ST_WRITE) && !(rsp.valid && !rsp.ready);

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) begin
          if (!hit_found && !way_match && !free_found && way_valid &&
              policy_mode == POL_RANDOM) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == 4'd0) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (ram_we) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // scan / divide datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        addr_q     <= req.address;
        set_q      <= rd_set;
        way        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        victim     <= '0;
      end
      ST_SCAN: begin
        way <= way + 3'd1;
        if (!hit_found && way_match) begin
          hit_found <= 1'b1;
          hit_way   <= way;
        end
        if (!free_found && !way_valid) begin
          free_found <= 1'b1;
          free_way   <= way;
        end
        if (way == '0) begin
          victim   <= '0;
          best_age <= way_age;
        end else if ((policy_mode == POL_MRU) ? (way_age < best_age)
                                              : (way_age > best_age)) begin
          victim   <= way;
          best_age <= way_age;
        end
        rem     <= '0;
        div_cnt <= 4'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        rem     <= div_r[WAY_W-1:0];
        div_cnt <= div_cnt - 4'd1;
        if (div_cnt == 4'd0) victim <= div_r[WAY_W-1:0];
      end
      ST_WRITE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[set_q] <= 1'b1;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ram_we) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      rsp.outcome         <= kind;
      rsp.evicted_address <= (kind == OUT_EVICT) ? row.addr[victim] : '0;
    end
  end

  `SACL_ASSERT_NOW(a_evict_zero, rsp.valid && rsp.outcome != OUT_EVICT,
                   rsp.evicted_address == '0)
  `SACL_ASSERT_NEXT(a_div_exit, state == ST_DIV,
                    state == ST_DIV || state == ST_WRITE)
  `SACL_ASSERT_NEXT(a_row_marked, ram_we, row_valid[set_q] && rsp.valid)
  `SACL_ASSERT_NOW(a_ready_idle, req.ready, state == ST_IDLE)

endmodule

@@ hdl/sacl_ram.sv @@
// ---------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative cache lookup block. A cache
// model in the bench predicts hit / fill / evict and the evicted address for
// every request transfer. Runs go through several register settings with
// random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import sacl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;   // worst lookup: accept, 8-way scan, random divide, write-back
  localparam int PHASE_ITEMS = 165;

  typedef struct {
    outcome_t             outcome;
    logic [ADDR_BITS-1:0] evicted;
  } lookup_result_t;

  // Cache model plus the queue of lookup results still owed by the block.
  class cache_scoreboard;
    int unsigned          off_bits, idx_bits, ways_reg, policy_reg;
    logic [15:0]          lfsr;
    bit                   valid_q [MAX_SETS][MAX_WAYS];
    logic [ADDR_BITS-1:0] addr_q  [MAX_SETS][MAX_WAYS];
    logic [2:0]           age_q   [MAX_SETS][MAX_WAYS];
    logic [3:0]           fill_q  [MAX_SETS];
    lookup_result_t       owed [$];
    int                   errors;

    function void clear();
      off_bits = 4; idx_bits = 4; ways_reg = 2; policy_reg = POL_LRU;
      lfsr = SEED_RESET;
      foreach (valid_q[s, w]) valid_q[s][w] = 0;
      foreach (fill_q[s]) fill_q[s] = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_OFFSET_BITS: off_bits = data[4:0];
        REG_INDEX_BITS:  idx_bits = data[3:0];
        REG_WAYS_IN_USE: ways_reg = data[3:0];
        REG_POLICY_MODE: policy_reg = data[1:0];
        REG_RANDOM_SEED: lfsr = (data == 0) ? 16'd1 : data;
        default: ;
      endcase
    endfunction

    function longint unsigned tag_of(logic [ADDR_BITS-1:0] a);
      longint unsigned wide;
      wide = a;
      return wide >> (off_bits + idx_bits);
    endfunction

    function int unsigned set_of(logic [ADDR_BITS-1:0] a);
      longint unsigned wide;
      wide = a;
      wide = (wide >> off_bits) & ((64'd1 << idx_bits) - 1);
      return wide % MAX_SETS;
    endfunction

    // age every valid active line younger than limit, saturating
    function void bump_ages(int unsigned s, int unsigned nw, int unsigned limit);
      for (int unsigned w = 0; w < nw; w++)
        if (valid_q[s][w] && age_q[s][w] < limit && age_q[s][w] < AGE_TOP)
          age_q[s][w]++;
    endfunction

    // accepted request: work out what the block must answer
    function void note_request(logic [ADDR_BITS-1:0] a);
      int unsigned    s, nw, victim;
      lookup_result_t r;
      s  = set_of(a);
      nw = (ways_reg < 1) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg;
      r.outcome = OUT_HIT;
      r.evicted = '0;
      for (int unsigned w = 0; w < nw; w++)
        if (valid_q[s][w] && tag_of(addr_q[s][w]) == tag_of(a)) begin
          bump_ages(s, nw, age_q[s][w]);
          age_q[s][w] = 0;
          owed.push_back(r);
          return;
        end
      for (int unsigned w = 0; w < nw; w++)
        if (!valid_q[s][w]) begin
          bump_ages(s, nw, AGE_TOP + 1);
          valid_q[s][w] = 1;
          addr_q[s][w]  = a;
          age_q[s][w]   = 0;
          if (fill_q[s] < FILL_TOP) fill_q[s]++;
          r.outcome = OUT_FILL;
          owed.push_back(r);
          return;
        end
      victim = 0;
      if (policy_reg == POL_RANDOM) begin
        lfsr   = {lfsr[14:0], lfsr[15] ^ lfsr[13] ^ lfsr[12] ^ lfsr[10]};
        victim = lfsr % nw;
      end else if (policy_reg == POL_MRU) begin
        for (int unsigned w = 1; w < nw; w++)
          if (age_q[s][w] < age_q[s][victim]) victim = w;
      end else begin
        // LRU, also for the unused mode code
        for (int unsigned w = 1; w < nw; w++)
          if (age_q[s][w] > age_q[s][victim]) victim = w;
      end
      r.outcome = OUT_EVICT;
      r.evicted = addr_q[s][victim];
      bump_ages(s, nw, age_q[s][victim]);
      addr_q[s][victim] = a;
      age_q[s][victim]  = 0;
      owed.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] outcome, logic [ADDR_BITS-1:0] evicted);
      lookup_result_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result outcome=%0d evicted=%h", outcome, evicted));
        return;
      end
      e = owed.pop_front();
      if (outcome !== e.outcome)
        report($sformatf("outcome %0d, want %0d", outcome, e.outcome));
      if (evicted !== e.evicted)
        report($sformatf("evicted %h, want %h", evicted, e.evicted));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  bit                   no_gaps = 1'b0;   // one phase runs with both sides busy
  int                   cycles = 0;
  cache_scoreboard      sb;

  sacl_req_if req ();
  sacl_rsp_if rsp ();

  set_assoc_cache_lookup_replace_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid   = 1'b0;
    req.address = '0;
    rsp.ready   = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random back-pressure, ~19% stalled
  always @(posedge clk) begin
    if (!rst) rsp.ready <= no_gaps || ($urandom_range(99) >= 19);
  end

  // result transfer monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) sb.check_result(rsp.outcome, rsp.evicted_address);
  end

  // Registers change only while idle. Valid for cfg_we is lowered once after
  // the whole batch so it never drops and rises in one step.
  task set_regs(int unsigned off, int unsigned idx, int unsigned ways,
                int unsigned pol, int unsigned seed);
    reg_idx_t             order [5];
    logic [CFG_DAT_W-1:0] vals  [5];
    order = '{REG_OFFSET_BITS, REG_INDEX_BITS, REG_WAYS_IN_USE, REG_POLICY_MODE,
              REG_RANDOM_SEED};
    vals  = '{CFG_DAT_W'(off), CFG_DAT_W'(idx), CFG_DAT_W'(ways), CFG_DAT_W'(pol),
              CFG_DAT_W'(seed)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      sb.write_reg(order[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one request transfer; each cycle in front idles with ~19% chance
  task send_request(logic [ADDR_BITS-1:0] a);
    while (!no_gaps && $urandom_range(99) < 19) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.address <= a;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(a);
  endtask

  task drain();
    req.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Mostly addresses from a small pool of tags and sets so that sets fill up,
  // hit and evict; the rest fully random.
  function logic [ADDR_BITS-1:0] pick_address();
    longint unsigned a;
    int unsigned     off, idx;
    off = sb.off_bits;
    idx = sb.idx_bits;
    if ($urandom_range(99) < 25) return $urandom;
    a = (longint'($urandom_range(0, 11)) << (off + idx))
      | (longint'($urandom_range(0, 3)) << off)
      | ({$urandom, $urandom} & ((64'd1 << off) - 1));
    return a[ADDR_BITS-1:0];
  endfunction

  typedef int unsigned phase_regs_t [5];
  phase_regs_t phases [9];

  initial begin
    logic [ADDR_BITS-1:0] directed [20];
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 16-byte lines, 16 sets, 2 ways, LRU
    directed = '{32'h0000_0000, 32'h0000_0100, 32'h0000_0004, 32'h0000_0200,
                 32'h0000_0100, 32'h0000_0300, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                 32'h0000_00F0, 32'hFFFF_FEF5, 32'h7FFF_FFF0, 32'h8000_0000,
                 32'h0000_0200, 32'h0000_0000, 32'h0000_0400, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hAAAA_AAA0, 32'h0000_0100, 32'h0000_0300};
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // offset, index, ways, policy, seed; extremes and out-of-range codes
    phases = '{'{0, 0, 1, POL_LRU, 1},         '{16, 8, 8, POL_MRU, 65535},
               '{31, 15, 15, POL_RANDOM, 0},   '{5, 3, 4, POL_RANDOM, 16'h1234},
               '{2, 6, 0, 3, 7},               '{10, 9, 3, POL_MRU, 16'h8000},
               '{1, 2, 8, POL_RANDOM, 16'hACE1}, '{0, 8, 5, POL_LRU, 2},
               '{4, 4, 2, POL_RANDOM, 44257}};
    foreach (phases[p]) begin
      set_regs(phases[p][0], phases[p][1], phases[p][2], phases[p][3], phases[p][4]);
      no_gaps = (p == 3);
      repeat (PHASE_ITEMS) send_request(pick_address());
      drain();
    end
    no_gaps = 1'b0;

    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
